// ===== design/rdh_pkg.sv =====
// Shared types and codes for the recapture displacement histogram.
`timescale 1ns / 1ps
`default_nettype none
package rdh_pkg;

  // Command modes
  localparam logic [1:0] MODE_RELEASE = 2'd0;
  localparam logic [1:0] MODE_BINTAB  = 2'd1;
  localparam logic [1:0] MODE_ADD     = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_COHORT = 2'd1;
  localparam logic [1:0] STAT_NEG_TIME = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RELEASE_COUNT = 2'd0;
  localparam logic [1:0] REG_MONTH_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MAX_BIN       = 2'd2;

  typedef struct packed {
    logic [15:0] cohort;
    logic [11:0] month;
    logic [7:0]  row;
    logic [7:0]  col;
  } rel_entry_t;

  typedef struct packed {
    logic       done;
    logic       found;
    rel_entry_t entry;
  } search_rsp_t;

endpackage
`default_nettype wire

// ===== design/recapture_displacement_histogram.sv =====
// Top level: command decode, bin table, histogram memory and update sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each command is taken when start is high and busy is low and gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Release and bin-table writes answer straight from ST_IDLE, a histogram read
// passes through ST_HIST, and a recapture add through ST_SEARCH, ST_BIN and
// ST_HIST: the release table is searched one entry per cycle through its
// single read port, then on a match the bin table and the histogram are read
// and the cell written back. After reset the histogram is cleared one cell per
// cycle, all MONTHS*BINS cells (4096 by default), with busy high; configuration
// writes are taken throughout.
module recapture_displacement_histogram #(
  parameter int RELEASES    = 64,
  parameter int GRID_SIZE   = 256,
  parameter int MONTHS      = 64,
  parameter int BINS        = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [5:0]  slot,
  input  wire logic [15:0] cohort,
  input  wire logic [11:0] month,
  input  wire logic [7:0]  cell_row,
  input  wire logic [7:0]  cell_col,
  input  wire logic [15:0] tag_returns,
  input  wire logic [5:0]  bin_value,
  input  wire logic [5:0]  read_month,
  input  wire logic [5:0]  read_bin,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      cell_count,
  output logic [5:0]       month_used,
  output logic [5:0]       bin_used
);

  localparam int BD = GRID_SIZE * GRID_SIZE;
  localparam int BW = (BD > 1) ? $clog2(BD) : 1;
  localparam int HD = MONTHS * BINS;
  localparam int HW = (HD > 1) ? $clog2(HD) : 1;
  localparam int SW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam logic [SW-1:0] COUNT_MAX = SW'({COUNT_WIDTH{1'b1}});

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_BIN    = 5'b01000,
    ST_HIST   = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [6:0] release_count;
  logic [5:0] month_limit;
  logic [5:0] max_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_count <= 7'd0;
      month_limit   <= 6'd63;
      max_bin       <= 6'd63;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        rdh_pkg::REG_RELEASE_COUNT: release_count <= cfg_data;
        rdh_pkg::REG_MONTH_LIMIT:   month_limit   <= cfg_data[5:0];
        rdh_pkg::REG_MAX_BIN:       max_bin       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Command registers
  logic [15:0] cohort_q;
  logic [11:0] month_q;
  logic [7:0]  row_q;
  logic [7:0]  col_q;
  logic [15:0] ret_q;
  logic        add_q;
  logic        inrange_q;
  logic [5:0]  tal_q;
  logic [5:0]  kk_q;
  logic [HW-1:0] clr_idx;
  logic [HW-1:0] hist_addr_q;

  // Effective caps
  logic [6:0] n_eff;
  logic [5:0] mcap;
  logic [5:0] bcap;
  logic [5:0] rd_m;
  logic [5:0] rd_b;

  always_comb begin
    n_eff = (32'(release_count) > RELEASES) ? 7'(RELEASES) : release_count;
    mcap  = (32'(month_limit) > MONTHS - 1) ? 6'(MONTHS - 1) : month_limit;
    bcap  = (32'(max_bin) > BINS - 1) ? 6'(BINS - 1) : max_bin;
    rd_m  = (32'(read_month) > MONTHS - 1) ? 6'(MONTHS - 1) : read_month;
    rd_b  = (32'(read_bin) > BINS - 1) ? 6'(BINS - 1) : read_bin;
  end

  logic accept;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Release table search
  rdh_pkg::rel_entry_t wr_entry;
  rdh_pkg::search_rsp_t rsp;
  logic go;

  assign wr_entry = '{cohort: cohort, month: month, row: cell_row, col: cell_col};
  assign go = accept && (mode == rdh_pkg::MODE_ADD) && (n_eff != 7'd0);

  rdh_release #(
    .RELEASES(RELEASES)
  ) u_release (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (mode == rdh_pkg::MODE_RELEASE)),
    .wr_slot (slot),
    .wr_entry(wr_entry),
    .go      (go),
    .cohort  (cohort_q),
    .count   (n_eff),
    .rsp     (rsp)
  );

  // Time at liberty and offsets from the matched release
  logic [11:0] dmonth;
  logic        neg_time;
  logic [5:0]  tal_c;
  logic [7:0]  dr;
  logic [7:0]  dc;
  logic        inrange_c;
  logic [BW-1:0] bin_raddr;

  always_comb begin
    dmonth    = month_q - rsp.entry.month;
    neg_time  = month_q < rsp.entry.month;
    tal_c     = (dmonth > 12'(mcap)) ? mcap : dmonth[5:0];
    dr        = (rsp.entry.row > row_q) ? rsp.entry.row - row_q : row_q - rsp.entry.row;
    dc        = (rsp.entry.col > col_q) ? rsp.entry.col - col_q : col_q - rsp.entry.col;
    inrange_c = (32'(dr) < GRID_SIZE) && (32'(dc) < GRID_SIZE);
    bin_raddr = BW'(32'(dr) * GRID_SIZE + 32'(dc));
  end

  // Distance bin table
  logic [5:0] bin_mem [BD];
  logic [5:0] bin_q;
  logic       bin_rd;
  logic       bin_wr;

  assign bin_rd = (state == ST_SEARCH) && rsp.done && rsp.found && !neg_time;
  assign bin_wr = accept && (mode == rdh_pkg::MODE_BINTAB)
                  && (32'(cell_row) < GRID_SIZE) && (32'(cell_col) < GRID_SIZE);

  always_ff @(posedge clk) begin
    if (bin_wr) begin
      bin_mem[BW'(32'(cell_row) * GRID_SIZE + 32'(cell_col))] <= bin_value;
    end
    if (bin_rd) begin
      bin_q <= bin_mem[bin_raddr];
    end
  end

  // Histogram memory controls
  logic [5:0]             kk_c;
  logic                   hist_rd;
  logic [HW-1:0]          hist_raddr;
  logic                   hist_we;
  logic [HW-1:0]          hist_waddr;
  logic [COUNT_WIDTH-1:0] hist_wdata;
  logic [COUNT_WIDTH-1:0] hist_q;
  logic [SW-1:0]          sum;
  logic [COUNT_WIDTH-1:0] new_cnt;

  always_comb begin
    kk_c = bcap;
    if (inrange_q && (bin_q < bcap)) begin
      kk_c = bin_q;
    end
    hist_rd    = 1'b0;
    hist_raddr = HW'(32'(tal_q) * BINS + 32'(kk_c));
    if (state == ST_BIN) begin
      hist_rd = 1'b1;
    end else if (accept && (mode == rdh_pkg::MODE_READ)) begin
      hist_rd    = 1'b1;
      hist_raddr = HW'(32'(rd_m) * BINS + 32'(rd_b));
    end
    // Saturating add of the returns
    sum     = SW'(hist_q) + SW'(ret_q);
    new_cnt = (sum > COUNT_MAX) ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(sum);
    hist_we    = 1'b0;
    hist_waddr = hist_addr_q;
    hist_wdata = new_cnt;
    if (state == ST_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_idx;
      hist_wdata = '0;
    end else if ((state == ST_HIST) && add_q) begin
      hist_we = 1'b1;
    end
  end

  logic [COUNT_WIDTH-1:0] hist_mem [HD];

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_rd) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  // Clamp a count to the 32-bit result field
  logic [COUNT_WIDTH-1:0] rep_src;
  logic [63:0]            rep64;
  logic [31:0]            rep_cnt;

  always_comb begin
    rep_src = add_q ? new_cnt : hist_q;
    rep64   = 64'(rep_src);
    rep_cnt = (rep64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rep64[31:0];
  end

  // Command payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cohort_q <= cohort;
      month_q  <= month;
      row_q    <= cell_row;
      col_q    <= cell_col;
      ret_q    <= tag_returns;
      add_q    <= (mode == rdh_pkg::MODE_ADD);
      tal_q    <= rd_m;
      kk_q     <= rd_b;
    end else if (bin_rd) begin
      tal_q     <= tal_c;
      inrange_q <= inrange_c;
    end else if (state == ST_BIN) begin
      kk_q <= kk_c;
    end
    if (hist_rd) begin
      hist_addr_q <= hist_raddr;
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + HW'(1);
          if (32'(clr_idx) == HD - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (mode) inside
              rdh_pkg::MODE_RELEASE, rdh_pkg::MODE_BINTAB: begin
                done       <= 1'b1;
                status     <= rdh_pkg::STAT_OK;
                cell_count <= '0;
                month_used <= '0;
                bin_used   <= '0;
              end
              rdh_pkg::MODE_ADD: begin
                if (n_eff == 7'd0) begin
                  done       <= 1'b1;
                  status     <= rdh_pkg::STAT_NO_COHORT;
                  cell_count <= '0;
                  month_used <= '0;
                  bin_used   <= '0;
                end else begin
                  state <= ST_SEARCH;
                end
              end
              default: begin
                state <= ST_HIST;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          if (rsp.done) begin
            if (!rsp.found || neg_time) begin
              done       <= 1'b1;
              status     <= rsp.found ? rdh_pkg::STAT_NEG_TIME : rdh_pkg::STAT_NO_COHORT;
              cell_count <= '0;
              month_used <= '0;
              bin_used   <= '0;
              state      <= ST_IDLE;
            end else begin
              state <= ST_BIN;
            end
          end
        end
        ST_BIN: begin
          state <= ST_HIST;
        end
        ST_HIST: begin
          done       <= 1'b1;
          status     <= rdh_pkg::STAT_OK;
          cell_count <= rep_cnt;
          month_used <= tal_q;
          bin_used   <= kk_q;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/rdh_release.sv =====
// Release table memory with a sequential first-match cohort search.
`timescale 1ns / 1ps
`default_nettype none
module rdh_release #(
  parameter int RELEASES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [5:0]         wr_slot,
  input  wire rdh_pkg::rel_entry_t wr_entry,
  input  wire logic               go,
  input  wire logic [15:0]        cohort,
  input  wire logic [6:0]         count,
  output rdh_pkg::search_rsp_t    rsp
);

  localparam int RW = (RELEASES > 1) ? $clog2(RELEASES) : 1;

  rdh_pkg::rel_entry_t mem [RELEASES];
  rdh_pkg::rel_entry_t rel_q;

  logic       active;
  logic [6:0] iss;
  logic       chk_valid;
  logic       chk_last;
  logic       hit;
  logic       issue;

  assign hit   = chk_valid && (rel_q.cohort == cohort);
  assign issue = active && !rsp.done && (iss < count);

  // Report the first match, or a miss once the last entry is checked
  always_comb begin
    rsp.done  = active && chk_valid && (hit || chk_last);
    rsp.found = hit;
    rsp.entry = rel_q;
  end

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_slot) < RELEASES)) begin
      mem[RW'(wr_slot)] <= wr_entry;
    end
    if (issue) begin
      rel_q <= mem[RW'(iss)];
    end
  end

  // Advance the search one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      iss       <= '0;
      chk_valid <= 1'b0;
      chk_last  <= 1'b0;
    end else if (go) begin
      active    <= 1'b1;
      iss       <= '0;
      chk_valid <= 1'b0;
      chk_last  <= 1'b0;
    end else if (active) begin
      if (rsp.done) begin
        active    <= 1'b0;
        chk_valid <= 1'b0;
      end else if (issue) begin
        chk_valid <= 1'b1;
        chk_last  <= (iss == count - 7'd1);
        iss       <= iss + 7'd1;
      end else begin
        chk_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_recapture_displacement_histogram.sv =====
// Self-checking testbench for the recapture displacement histogram block.
`timescale 1ns / 1ps
module tb_recapture_displacement_histogram;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 90;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  slot;
    logic [15:0] cohort;
    logic [11:0] month;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] returns;
    logic [5:0]  binv;
    logic [5:0]  rmonth;
    logic [5:0]  rbin;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] count;
    logic [5:0]  month;
    logic [5:0]  bin;
  } hist_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = rdh_pkg::REG_RELEASE_COUNT;
  logic [6:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = rdh_pkg::MODE_RELEASE;
  logic [5:0]  slot = '0;
  logic [15:0] cohort = '0;
  logic [11:0] month = '0;
  logic [7:0]  cell_row = '0;
  logic [7:0]  cell_col = '0;
  logic [15:0] tag_returns = '0;
  logic [5:0]  bin_value = '0;
  logic [5:0]  read_month = '0;
  logic [5:0]  read_bin = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] cell_count;
  logic [5:0]  month_used;
  logic [5:0]  bin_used;

  recapture_displacement_histogram i_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .mode(mode), .slot(slot), .cohort(cohort), .month(month),
    .cell_row(cell_row), .cell_col(cell_col), .tag_returns(tag_returns),
    .bin_value(bin_value), .read_month(read_month), .read_bin(read_bin), .done(done),
    .status(status), .cell_count(cell_count), .month_used(month_used), .bin_used(bin_used)
  );

  // Configuration shadow, changed with each register write; the first writes land while the block still clears
  logic [6:0] release_count = 7'd0;
  logic [5:0] month_limit = 6'd63;
  logic [5:0] max_bin = 6'd63;

  // Predictor copy of the block state
  logic [15:0] rel_cohort [0:63];
  logic [11:0] rel_month [0:63];
  logic [7:0]  rel_row [0:63];
  logic [7:0]  rel_col [0:63];
  logic [5:0]  dist_bin [0:65535];
  logic [31:0] hist [0:4095];

  // Stimulus-side view of what has been written, so no unwritten entry is read
  logic [15:0] gen_cohort [0:63];
  logic [11:0] gen_month [0:63];
  logic [7:0]  gen_row [0:63];
  logic [7:0]  gen_col [0:63];
  bit          gen_rel_wr [0:63];
  bit          gen_bin_wr [0:65535];
  logic [15:0] cohort_pool [0:9];

  cmd_t         cmd_q [$];
  hist_result_t expected_q [$];
  cmd_t         cur;
  int           idle_left = 0;
  bit           no_idle = 0;
  int           errors = 0;
  int           cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Compute the result of one accepted command and update the predictor tables
  task automatic predict_histogram(input cmd_t c);
    hist_result_t r;
    int n;
    int idx;
    bit found;
    logic [5:0] tal;
    logic [5:0] kk;
    logic [7:0] dr;
    logic [7:0] dc;
    logic [32:0] sum;
    logic [11:0] diff;
    r = '{rdh_pkg::STAT_OK, 32'd0, 6'd0, 6'd0};
    found = 0;
    idx = 0;
    case (c.mode)
      rdh_pkg::MODE_RELEASE: begin
        rel_cohort[c.slot] = c.cohort;
        rel_month[c.slot] = c.month;
        rel_row[c.slot] = c.row;
        rel_col[c.slot] = c.col;
      end
      rdh_pkg::MODE_BINTAB: dist_bin[{c.row, c.col}] = c.binv;
      rdh_pkg::MODE_ADD: begin
        n = (release_count > 7'd64) ? 64 : int'(release_count);
        for (int i = 0; i < n; i++) begin
          if (!found && rel_cohort[i] == c.cohort) begin
            found = 1;
            idx = i;
          end
        end
        if (!found) begin
          r.status = rdh_pkg::STAT_NO_COHORT;
        end else if (c.month < rel_month[idx]) begin
          r.status = rdh_pkg::STAT_NEG_TIME;
        end else begin
          diff = c.month - rel_month[idx];
          tal = (diff > 12'(month_limit)) ? month_limit : diff[5:0];
          dr = (rel_row[idx] > c.row) ? rel_row[idx] - c.row : c.row - rel_row[idx];
          dc = (rel_col[idx] > c.col) ? rel_col[idx] - c.col : c.col - rel_col[idx];
          kk = (dist_bin[{dr, dc}] > max_bin) ? max_bin : dist_bin[{dr, dc}];
          sum = {1'b0, hist[{tal, kk}]} + 33'(c.returns);
          hist[{tal, kk}] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          r.count = hist[{tal, kk}];
          r.month = tal;
          r.bin = kk;
        end
      end
      default: begin
        r.count = hist[{c.rmonth, c.rbin}];
        r.month = c.rmonth;
        r.bin = c.rbin;
      end
    endcase
    expected_q.push_back(r);
  endtask

  function automatic cmd_t random_cmd(input logic [1:0] m);
    cmd_t c;
    c.mode = m;
    c.slot = 6'($urandom);
    c.cohort = 16'($urandom);
    c.month = 12'($urandom);
    c.row = 8'($urandom);
    c.col = 8'($urandom);
    c.returns = 16'($urandom);
    c.binv = 6'($urandom);
    c.rmonth = 6'($urandom);
    c.rbin = 6'($urandom);
    return c;
  endfunction

  task automatic queue_release(input logic [5:0] s, input logic [15:0] co,
                               input logic [11:0] mo, input logic [7:0] r, input logic [7:0] c);
    cmd_t x;
    x = random_cmd(rdh_pkg::MODE_RELEASE);
    x.slot = s; x.cohort = co; x.month = mo; x.row = r; x.col = c;
    gen_cohort[s] = co; gen_month[s] = mo; gen_row[s] = r; gen_col[s] = c;
    gen_rel_wr[s] = 1;
    cmd_q.push_back(x);
  endtask

  task automatic queue_bin(input logic [7:0] r, input logic [7:0] c, input logic [5:0] b);
    cmd_t x;
    x = random_cmd(rdh_pkg::MODE_BINTAB);
    x.row = r; x.col = c; x.binv = b;
    gen_bin_wr[{r, c}] = 1;
    cmd_q.push_back(x);
  endtask

  // Queue a recapture, first loading the bin entry its offset will look up if not yet written
  task automatic queue_add(input logic [15:0] co, input logic [11:0] mo,
                           input logic [7:0] r, input logic [7:0] c, input logic [15:0] ret);
    cmd_t x;
    int n;
    int idx;
    logic [7:0] dr;
    logic [7:0] dc;
    idx = -1;
    n = (release_count > 7'd64) ? 64 : int'(release_count);
    for (int i = 0; i < n; i++)
      if (idx < 0 && gen_cohort[i] == co) idx = i;
    if (idx >= 0 && mo >= gen_month[idx]) begin
      dr = (gen_row[idx] > r) ? gen_row[idx] - r : r - gen_row[idx];
      dc = (gen_col[idx] > c) ? gen_col[idx] - c : c - gen_col[idx];
      if (!gen_bin_wr[{dr, dc}]) queue_bin(dr, dc, 6'($urandom));
    end
    x = random_cmd(rdh_pkg::MODE_ADD);
    x.cohort = co; x.month = mo; x.row = r; x.col = c; x.returns = ret;
    cmd_q.push_back(x);
  endtask

  task automatic queue_read(input logic [5:0] m, input logic [5:0] b);
    cmd_t x;
    x = random_cmd(rdh_pkg::MODE_READ);
    x.rmonth = m; x.rbin = b;
    cmd_q.push_back(x);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rdh_pkg::REG_RELEASE_COUNT: release_count = val;
      rdh_pkg::REG_MONTH_LIMIT: month_limit = val[5:0];
      default: max_bin = val[5:0];
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    while (cmd_q.size() != 0 || start || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mixed releases, bin writes and reads, mostly recaptures with known cohorts and months close to the release
  task automatic random_phase(input int items);
    int s;
    int pick;
    logic [15:0] co;
    logic [11:0] mo;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_release(6'($urandom), cohort_pool[$urandom_range(0, 9)], 12'($urandom),
                      8'($urandom), 8'($urandom));
      end else if (pick < 27) begin
        queue_bin(8'($urandom), 8'($urandom), 6'($urandom));
      end else if (pick < 85) begin
        s = $urandom_range(0, 63);
        co = ($urandom_range(0, 9) == 0) ? 16'($urandom) : gen_cohort[s];
        mo = gen_month[s] + 12'($urandom_range(0, 90));
        if ($urandom_range(0, 7) == 0) mo = 12'($urandom);
        if (mo < gen_month[s] && $urandom_range(0, 1) == 0) mo = gen_month[s];
        queue_add(co, mo, 8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        queue_read(6'($urandom), 6'($urandom));
      end
    end
  endtask

  // Driver: launch queued commands with a random gap after each transfer unless no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) predict_histogram(cur);
      if (start && busy) begin
        // hold the command until it is taken
      end else if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        cur = cmd_q.pop_front();
        mode <= cur.mode;
        slot <= cur.slot;
        cohort <= cur.cohort;
        month <= cur.month;
        cell_row <= cur.row;
        cell_col <= cur.col;
        tag_returns <= cur.returns;
        bin_value <= cur.binv;
        read_month <= cur.rmonth;
        read_bin <= cur.rbin;
        start <= 1'b1;
        idle_left <= no_idle ? 0 : int'($urandom_range(0, 13));
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    hist_result_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report("unexpected result, status", 32'(status), 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (status !== e.status) report("status", 32'(status), 32'(e.status));
        if (cell_count !== e.count) report("cell_count", cell_count, e.count);
        if (month_used !== e.month) report("month_used", 32'(month_used), 32'(e.month));
        if (bin_used !== e.bin) report("bin_used", 32'(bin_used), 32'(e.bin));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int n_ok;
    for (int i = 0; i < 64; i++) gen_rel_wr[i] = 0;
    for (int i = 0; i < 65536; i++) gen_bin_wr[i] = 0;
    for (int i = 0; i < 4096; i++) hist[i] = '0;
    for (int i = 0; i < 10; i++) cohort_pool[i] = 16'($urandom);
    cohort_pool[0] = 16'h0000;
    cohort_pool[1] = 16'hFFFF;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty release table, extreme entries and offsets
    write_reg(rdh_pkg::REG_RELEASE_COUNT, 7'd0);
    write_reg(rdh_pkg::REG_MONTH_LIMIT, 7'd63);
    write_reg(rdh_pkg::REG_MAX_BIN, 7'd63);
    queue_add(16'hFFFF, 12'd100, 8'd3, 8'd4, 16'd7);
    queue_read(6'd0, 6'd0);
    queue_read(6'd63, 6'd63);
    queue_release(6'd0, 16'hFFFF, 12'd0, 8'd0, 8'd0);
    queue_release(6'd1, 16'h0000, 12'd4095, 8'd255, 8'd255);
    queue_release(6'd63, 16'h5A5A, 12'd2048, 8'd128, 8'd1);
    queue_bin(8'd0, 8'd0, 6'd63);
    queue_bin(8'd255, 8'd255, 6'd0);
    queue_bin(8'd0, 8'd255, 6'd21);
    drain();

    write_reg(rdh_pkg::REG_RELEASE_COUNT, 7'd2);
    queue_add(16'hFFFF, 12'd4095, 8'd255, 8'd255, 16'hFFFF);
    queue_add(16'h0000, 12'd0, 8'd0, 8'd0, 16'd1);
    queue_add(16'h0000, 12'd4095, 8'd255, 8'd255, 16'd0);
    queue_add(16'h0000, 12'd4095, 8'd255, 8'd0, 16'd9);
    queue_add(16'h1234, 12'd50, 8'd9, 8'd9, 16'd5);
    queue_read(6'd63, 6'd0);
    queue_read(6'd0, 6'd63);
    drain();

    // Pile adds onto row 0, column 0 back to back
    write_reg(rdh_pkg::REG_RELEASE_COUNT, 7'd1);
    write_reg(rdh_pkg::REG_MONTH_LIMIT, 7'd0);
    write_reg(rdh_pkg::REG_MAX_BIN, 7'd0);
    no_idle = 1;
    for (int i = 0; i < 8; i++) queue_add(16'hFFFF, 12'($urandom), 8'd0, 8'd0, 16'hFFFF);
    queue_read(6'd0, 6'd0);
    drain();

    // Random phases, filling the release table first
    for (int ph = 0; ph < 6; ph++) begin
      n_ok = 0;
      while (n_ok < 64 && gen_rel_wr[n_ok]) n_ok++;
      no_idle = (ph == 2);
      if (ph == 0) begin
        write_reg(rdh_pkg::REG_MONTH_LIMIT, 7'd0);
        write_reg(rdh_pkg::REG_MAX_BIN, 7'd0);
      end else if (ph == 1) begin
        write_reg(rdh_pkg::REG_RELEASE_COUNT, 7'd64);
        write_reg(rdh_pkg::REG_MONTH_LIMIT, 7'd63);
        write_reg(rdh_pkg::REG_MAX_BIN, 7'd63);
      end else begin
        write_reg(rdh_pkg::REG_RELEASE_COUNT,
                  (ph == 5) ? 7'd127 : 7'($urandom_range(0, n_ok)));
        write_reg(rdh_pkg::REG_MONTH_LIMIT, 7'($urandom_range(0, 63)));
        write_reg(rdh_pkg::REG_MAX_BIN, 7'($urandom_range(0, 63)));
      end
      if (ph == 0)
        for (int s = 0; s < 64; s++)
          queue_release(6'(s), cohort_pool[$urandom_range(0, 9)],
                        12'($urandom_range(0, 4000)), 8'($urandom), 8'($urandom));
      random_phase(36);
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rdh_pkg.sv
design/rdh_release.sv
design/recapture_displacement_histogram.sv
tb/tb_recapture_displacement_histogram.sv
